FILE: rtl/core/clsh_pkg.sv
// Shared constants, widths and codes for the chunk LOD select block.
package clsh_pkg;

  localparam int LEVELS     = 4;
  localparam int MAX_CHUNKS = 256;

  localparam int IDX_W   = 8;
  localparam int LVL_W   = 3;
  localparam int COORD_W = 24;
  localparam int DIFF_W  = COORD_W + 1;
  localparam int MAG_W   = COORD_W;
  localparam int PROD_W  = 2 * MAG_W;
  localparam int SQ_W    = 50;
  localparam int ROOT_W  = SQ_W / 2;
  localparam int REM_W   = ROOT_W + 2;
  localparam int CNT_W   = 5;
  localparam int FD_W    = 24;
  localparam int MF_W    = 15;
  localparam int FAC_W   = 17;
  localparam int THR_W   = FD_W + 8;
  localparam int CMP_W   = PROD_W + 8;
  localparam int FRAC_W  = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;

  localparam logic [FD_W-1:0]  FIRST_DIST_RST = FD_W'(16384);
  localparam logic [MF_W-1:0]  MARGIN_RST     = MF_W'(6554);
  localparam logic [FAC_W-1:0] FAC_ONE        = FAC_W'(65536);
  localparam logic [LVL_W-1:0] LVL_UNBUILT    = LVL_W'(LEVELS);
  localparam logic [CNT_W-1:0] ROOT_STEPS_M1  = CNT_W'(ROOT_W - 1);

  localparam logic OP_EVAL = 1'b0;
  localparam logic OP_MARK = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FIRST_DIST = 2'd0,
    CFG_MARGIN     = 2'd1
  } cfg_reg_t;

endpackage

FILE: rtl/core/clsh_ram.sv
// Generic single-port RAM with registered read data.
module clsh_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[addr] <= wdata;
    end
    rdata <= mem_r[addr];
  end

endmodule

FILE: rtl/core/chunk_lod_select_hysteresis_unit.sv
// Top level: per-chunk LOD selection with distance bands and hysteresis.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+------------------------------------------
//  in_     | in        | in_valid / in_stall  | op, chunk_index, center_x/z, viewer_x/z,
//          |           |                      | radius
//  out_    | out       | out_valid / out_stall| new_level, rebuild
//  cfg_    | in        | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// An evaluate item walks the states SQX and SQZ on the shared 24x24 multiplier for dx^2 and
// dz^2, SUM for one add, ROOT for the bit-serial square root, then DIST for the distance,
// BAND for the band, MUL for one more multiply for the hysteresis boundary and DONE for the
// final compare. A mark item goes from IDLE straight to DONE; in_stall stays high until IDLE.
// Reset (rst_n low, synchronous) clears all level-table valid bits, so every chunk reads
// as unbuilt, and loads the config registers with their defaults.
// The result sits in an output register; out_stall only holds the sequencer in its last
// state when that register is still full, so the next item may be taken meanwhile.
module chunk_lod_select_hysteresis_unit (
  input  logic                               clk,
  input  logic                               rst_n,
  // item input
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic                               in_op,
  input  logic [clsh_pkg::IDX_W-1:0]         in_chunk_index,
  input  logic signed [clsh_pkg::COORD_W-1:0] in_center_x,
  input  logic signed [clsh_pkg::COORD_W-1:0] in_center_z,
  input  logic signed [clsh_pkg::COORD_W-1:0] in_viewer_x,
  input  logic signed [clsh_pkg::COORD_W-1:0] in_viewer_z,
  input  logic [clsh_pkg::COORD_W-1:0]       in_radius,
  // result output
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [clsh_pkg::LVL_W-1:0]         out_new_level,
  output logic                               out_rebuild,
  // config writes
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [clsh_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [clsh_pkg::CFG_DATA_W-1:0]    cfg_data
);

  // One-hot sequencer
  typedef enum logic [8:0] {
    ST_IDLE = 9'b000000001,
    ST_SQX  = 9'b000000010,
    ST_SQZ  = 9'b000000100,
    ST_SUM  = 9'b000001000,
    ST_ROOT = 9'b000010000,
    ST_DIST = 9'b000100000,
    ST_BAND = 9'b001000000,
    ST_MUL  = 9'b010000000,
    ST_DONE = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;

  // config registers
  logic [clsh_pkg::FD_W-1:0] fd_r;
  logic [clsh_pkg::MF_W-1:0] mf_r;

  // item registers
  logic [clsh_pkg::IDX_W-1:0]  idx_r;
  logic                        mark_r;
  logic [clsh_pkg::MAG_W-1:0]  mag_x_r, mag_z_r;
  logic [clsh_pkg::COORD_W-1:0] rad_r;
  logic [clsh_pkg::PROD_W-1:0] prod_r;
  logic [clsh_pkg::SQ_W-1:0]   sq_r;
  logic [clsh_pkg::REM_W-1:0]  rem_r;
  logic [clsh_pkg::ROOT_W-1:0] root_r;
  logic [clsh_pkg::CNT_W-1:0]  cnt_r;
  logic [clsh_pkg::ROOT_W-1:0] dist_r;
  logic [clsh_pkg::LVL_W-1:0]  old_r, wanted_r;

  // level table: RAM plus one valid bit per entry
  logic [clsh_pkg::MAX_CHUNKS-1:0] valid_r;
  logic                            ram_we;
  logic [clsh_pkg::IDX_W-1:0]      ram_addr;
  logic [clsh_pkg::LVL_W-1:0]      ram_rdata;

  // output register
  logic                       out_valid_r;
  logic [clsh_pkg::LVL_W-1:0] out_level_r;
  logic                       out_rebuild_r;

  logic in_acc;
  assign in_stall  = (state_r != ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  assign out_valid     = out_valid_r;
  assign out_new_level = out_level_r;
  assign out_rebuild   = out_rebuild_r;

  // coordinate deltas, magnitudes fit in 24 bits
  logic signed [clsh_pkg::DIFF_W-1:0] dx_c, dz_c, ndx_c, ndz_c;
  assign dx_c  = clsh_pkg::DIFF_W'(in_center_x) - clsh_pkg::DIFF_W'(in_viewer_x);
  assign dz_c  = clsh_pkg::DIFF_W'(in_center_z) - clsh_pkg::DIFF_W'(in_viewer_z);
  assign ndx_c = -dx_c;
  assign ndz_c = -dz_c;

  // shared multiplier
  logic [clsh_pkg::MAG_W-1:0] mul_a, mul_b;
  logic [clsh_pkg::PROD_W-1:0] mul_p;
  logic                        coarser_c;
  logic [clsh_pkg::FAC_W-1:0]  factor_c;

  assign coarser_c = (wanted_r > old_r);
  assign factor_c  = coarser_c ? (clsh_pkg::FAC_ONE + clsh_pkg::FAC_W'(mf_r))
                               : (clsh_pkg::FAC_ONE - clsh_pkg::FAC_W'(mf_r));

  always_comb begin
    unique case (state_r)
      ST_SQX: begin
        mul_a = mag_x_r;
        mul_b = mag_x_r;
      end
      ST_SQZ: begin
        mul_a = mag_z_r;
        mul_b = mag_z_r;
      end
      default: begin
        mul_a = fd_r;
        mul_b = clsh_pkg::MAG_W'(factor_c);
      end
    endcase
  end
  assign mul_p = clsh_pkg::PROD_W'(mul_a) * clsh_pkg::PROD_W'(mul_b);

  // one square-root digit per cycle
  logic [clsh_pkg::REM_W+1:0] rem_sh_c, trial_c;
  logic                       take_c;
  assign rem_sh_c = {rem_r, sq_r[clsh_pkg::SQ_W-1 -: 2]};
  assign trial_c  = (clsh_pkg::REM_W+2)'({root_r, 2'b01});
  assign take_c   = (rem_sh_c >= trial_c);

  // band: count thresholds cleared (thresholds are monotone)
  logic [clsh_pkg::LVL_W-1:0] band_c;
  always_comb begin
    band_c = '0;
    for (int j = 0; j < clsh_pkg::LEVELS - 1; j++) begin
      if (clsh_pkg::THR_W'(dist_r) >= (clsh_pkg::THR_W'(fd_r) << j)) begin
        band_c = band_c + clsh_pkg::LVL_W'(1);
      end
    end
  end

  // hysteresis compare against the scaled boundary
  logic [clsh_pkg::LVL_W-1:0] shamt_c;
  logic [clsh_pkg::CMP_W-1:0] lhs_c, rhs_c;
  logic                       hold_c;
  logic [clsh_pkg::LVL_W-1:0] final_c;
  logic                       rebuild_c;
  logic                       out_free;

  assign shamt_c = coarser_c ? old_r : (old_r - clsh_pkg::LVL_W'(1));
  assign lhs_c   = clsh_pkg::CMP_W'({dist_r, {clsh_pkg::FRAC_W{1'b0}}});
  assign rhs_c   = clsh_pkg::CMP_W'(prod_r) << shamt_c;

  always_comb begin
    hold_c = 1'b0;
    if ((old_r < clsh_pkg::LVL_UNBUILT) && (wanted_r != old_r)) begin
      hold_c = coarser_c ? (lhs_c < rhs_c) : (lhs_c > rhs_c);
    end
    final_c   = hold_c ? old_r : wanted_r;
    rebuild_c = (final_c != old_r);
  end

  assign out_free = !out_valid_r || !out_stall;

  // RAM port: read on accept, write when an evaluate result that needs a rebuild leaves
  assign ram_addr = (state_r == ST_IDLE) ? in_chunk_index : idx_r;
  assign ram_we   = (state_r == ST_DONE) && out_free && !mark_r && rebuild_c;

  clsh_ram #(
    .WIDTH (clsh_pkg::LVL_W),
    .DEPTH (clsh_pkg::MAX_CHUNKS)
  ) u_level_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (final_c),
    .rdata (ram_rdata)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          state_nxt = (in_op == clsh_pkg::OP_MARK) ? ST_DONE : ST_SQX;
        end
      end
      ST_SQX:  state_nxt = ST_SQZ;
      ST_SQZ:  state_nxt = ST_SUM;
      ST_SUM:  state_nxt = ST_ROOT;
      ST_ROOT: begin
        if (cnt_r == '0) begin
          state_nxt = ST_DIST;
        end
      end
      ST_DIST: state_nxt = ST_BAND;
      ST_BAND: state_nxt = ST_MUL;
      ST_MUL:  state_nxt = ST_DONE;
      ST_DONE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      valid_r     <= '0;
      out_valid_r <= 1'b0;
      fd_r        <= clsh_pkg::FIRST_DIST_RST;
      mf_r        <= clsh_pkg::MARGIN_RST;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          clsh_pkg::CFG_FIRST_DIST: fd_r <= cfg_data[clsh_pkg::FD_W-1:0];
          clsh_pkg::CFG_MARGIN:     mf_r <= cfg_data[clsh_pkg::MF_W-1:0];
          default: ;
        endcase
      end
      if (in_acc && (in_op == clsh_pkg::OP_MARK)) begin
        valid_r[in_chunk_index] <= 1'b0;
      end
      if (ram_we) begin
        valid_r[idx_r] <= 1'b1;
      end
      if ((state_r == ST_DONE) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          idx_r   <= in_chunk_index;
          mark_r  <= (in_op == clsh_pkg::OP_MARK);
          rad_r   <= in_radius;
          mag_x_r <= dx_c[clsh_pkg::DIFF_W-1] ? ndx_c[clsh_pkg::MAG_W-1:0]
                                              : dx_c[clsh_pkg::MAG_W-1:0];
          mag_z_r <= dz_c[clsh_pkg::DIFF_W-1] ? ndz_c[clsh_pkg::MAG_W-1:0]
                                              : dz_c[clsh_pkg::MAG_W-1:0];
        end
      end
      ST_SQX: begin
        prod_r <= mul_p;
        old_r  <= valid_r[idx_r] ? ram_rdata : clsh_pkg::LVL_UNBUILT;
      end
      ST_SQZ: begin
        sq_r   <= clsh_pkg::SQ_W'(prod_r);
        prod_r <= mul_p;
      end
      ST_SUM: begin
        sq_r   <= sq_r + clsh_pkg::SQ_W'(prod_r);
        rem_r  <= '0;
        root_r <= '0;
        cnt_r  <= clsh_pkg::ROOT_STEPS_M1;
      end
      ST_ROOT: begin
        sq_r  <= sq_r << 2;
        cnt_r <= cnt_r - clsh_pkg::CNT_W'(1);
        if (take_c) begin
          rem_r  <= clsh_pkg::REM_W'(rem_sh_c - trial_c);
          root_r <= {root_r[clsh_pkg::ROOT_W-2:0], 1'b1};
        end else begin
          rem_r  <= clsh_pkg::REM_W'(rem_sh_c);
          root_r <= {root_r[clsh_pkg::ROOT_W-2:0], 1'b0};
        end
      end
      ST_DIST: begin
        dist_r <= (root_r > clsh_pkg::ROOT_W'(rad_r))
                  ? (root_r - clsh_pkg::ROOT_W'(rad_r)) : '0;
      end
      ST_BAND: begin
        wanted_r <= band_c;
      end
      ST_MUL: begin
        prod_r <= mul_p;
      end
      ST_DONE: begin
        if (out_free) begin
          out_level_r   <= mark_r ? clsh_pkg::LVL_UNBUILT : final_c;
          out_rebuild_r <= mark_r ? 1'b0 : rebuild_c;
        end
      end
      default: ;
    endcase
  end

  // checks
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> in_stall)
    else $error("block took an item without going busy");

  a_root_length: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_ROOT) && (cnt_r == '0) |=> (state_r == ST_DIST))
    else $error("square root did not end after its last digit");

  a_mark_clears: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && (in_op == clsh_pkg::OP_MARK) |=> !valid_r[idx_r])
    else $error("mark left the table entry valid");

  a_rebuild_built: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_rebuild_r |-> (out_level_r < clsh_pkg::LVL_UNBUILT))
    else $error("rebuild flagged for an unbuilt level");

endmodule

FILE: verif/chunk_lod_select_hysteresis_unit_tb.sv
// Testbench for the chunk LOD select unit: directed and random items against a level-table predictor.
`timescale 1ns / 1ps

module chunk_lod_select_hysteresis_unit_tb;
  import clsh_pkg::*;

  // Clock, drain pad and watchdog limits. The pad after the last result covers one full
  // evaluate item in the block.
  localparam int CLK_HALF       = 4;
  localparam int RESET_CYCLES   = 11;
  localparam int SETTLE_CYCLES  = 40;
  localparam int HOLD_CYCLES    = 300;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int RANDOM_ITEMS   = 410;
  localparam int CHUNK_POOL     = 12;

  // One input item and one result as the block sees them.
  typedef struct {
    logic                      op;
    logic [IDX_W-1:0]          idx;
    logic signed [COORD_W-1:0] cx;
    logic signed [COORD_W-1:0] cz;
    logic signed [COORD_W-1:0] vx;
    logic signed [COORD_W-1:0] vz;
    logic [COORD_W-1:0]        rad;
  } lod_item_t;

  typedef struct {
    logic [LVL_W-1:0] level;
    logic             rebuild;
  } lod_result_t;

  logic                      clk;
  logic                      rst_n;
  logic                      in_valid;
  logic                      in_stall;
  logic                      in_op;
  logic [IDX_W-1:0]          in_chunk_index;
  logic signed [COORD_W-1:0] in_center_x;
  logic signed [COORD_W-1:0] in_center_z;
  logic signed [COORD_W-1:0] in_viewer_x;
  logic signed [COORD_W-1:0] in_viewer_z;
  logic [COORD_W-1:0]        in_radius;
  logic                      out_valid;
  logic                      out_stall;
  logic [LVL_W-1:0]          out_new_level;
  logic                      out_rebuild;
  logic                      cfg_valid;
  logic                      cfg_ready;
  logic [CFG_IDX_W-1:0]      cfg_index;
  logic [CFG_DATA_W-1:0]     cfg_data;

  // Predictor state: its own copy of the level table and of both registers.
  logic [LVL_W-1:0] level_tbl [MAX_CHUNKS];
  logic [FD_W-1:0]  model_first_dist;
  logic [MF_W-1:0]  model_margin;

  lod_result_t level_expect_q[$];
  int          fail_cnt;
  int          send_idle_pct;
  int          stall_pct;
  bit          hold_req;
  int          quiet_cycles;

  chunk_lod_select_hysteresis_unit dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_op          (in_op),
    .in_chunk_index (in_chunk_index),
    .in_center_x    (in_center_x),
    .in_center_z    (in_center_z),
    .in_viewer_x    (in_viewer_x),
    .in_viewer_z    (in_viewer_z),
    .in_radius      (in_radius),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_new_level  (out_new_level),
    .out_rebuild    (out_rebuild),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  // ---------------------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------------------

  // Bitwise floor square root: builds the root from the top bit down. Squares stay below
  // 2^50, so the root fits in 25 bits.
  function automatic longint unsigned floor_sqrt(input longint unsigned x);
    longint unsigned r;
    longint unsigned t;
    r = 0;
    for (int b = ROOT_W; b >= 0; b--) begin
      t = r | (64'd1 << b);
      if (t * t <= x) r = t;
    end
    return r;
  endfunction

  // Expected result of one accepted item; updates the level table as the block should.
  function automatic lod_result_t select_level(input lod_item_t it);
    lod_result_t     res;
    longint          dx;
    longint          dz;
    longint unsigned root;
    longint unsigned distance;
    longint unsigned thr;
    longint unsigned lhs;
    longint unsigned bnd;
    longint unsigned fd;
    int              wanted;
    int              held;
    res.level   = LVL_UNBUILT;
    res.rebuild = 1'b0;
    if (int'(it.idx) >= MAX_CHUNKS) return res;
    if (it.op == OP_MARK) begin
      level_tbl[it.idx] = LVL_UNBUILT;
      return res;
    end
    fd   = longint'(model_first_dist);
    dx   = longint'(it.cx) - longint'(it.vx);
    dz   = longint'(it.cz) - longint'(it.vz);
    root = floor_sqrt(longint'(dx * dx + dz * dz));
    distance = (root > longint'(it.rad)) ? root - longint'(it.rad) : 0;
    // Plain band: thresholds double from first_distance, capped at LEVELS-1.
    wanted = 0;
    thr    = fd;
    while (wanted < LEVELS - 1 && distance >= thr) begin
      thr = thr << 1;
      wanted++;
    end
    held = int'(level_tbl[it.idx]);
    // Hysteresis only for a built chunk: the distance must clear the boundary by the margin.
    if (held < LEVELS && wanted != held) begin
      lhs = distance << FRAC_W;
      if (wanted > held) begin
        bnd = fd << held;
        if (lhs < bnd * (longint'(FAC_ONE) + longint'(model_margin))) wanted = held;
      end else begin
        bnd = fd << (held - 1);
        if (lhs > bnd * (longint'(FAC_ONE) - longint'(model_margin))) wanted = held;
      end
    end
    if (wanted != held) begin
      level_tbl[it.idx] = LVL_W'(wanted);
      res.rebuild       = 1'b1;
    end
    res.level = LVL_W'(wanted);
    return res;
  endfunction

  // ---------------------------------------------------------------------------------------
  // Item builders
  // ---------------------------------------------------------------------------------------

  // Evaluate with the chunk at distance d on the x axis from a viewer at the origin.
  function automatic lod_item_t dist_item(input int idx, input int d);
    lod_item_t it;
    it.op  = OP_EVAL;
    it.idx = IDX_W'(idx);
    it.cx  = COORD_W'(d);
    it.cz  = '0;
    it.vx  = '0;
    it.vz  = '0;
    it.rad = '0;
    return it;
  endfunction

  function automatic lod_item_t mark_item(input int idx);
    lod_item_t it;
    it     = dist_item(idx, 0);
    it.op  = OP_MARK;
    return it;
  endfunction

  // Random traffic: mostly repeated chunks at distances near a band boundary, so that
  // hysteresis is exercised both ways; the rest is raw random fields and marks.
  function automatic lod_item_t draw_traffic_item();
    lod_item_t       it;
    int              pick;
    int              k;
    longint          b;
    longint          span;
    longint          d;
    longint          dx;
    longint          vpos;
    longint          perp;
    longint unsigned rad;
    pick   = $urandom_range(99);
    it.op  = OP_EVAL;
    it.idx = ($urandom_range(3) != 0) ? IDX_W'($urandom_range(CHUNK_POOL - 1))
                                      : IDX_W'($urandom());
    it.cx  = COORD_W'($urandom());
    it.cz  = COORD_W'($urandom());
    it.vx  = COORD_W'($urandom());
    it.vz  = COORD_W'($urandom());
    it.rad = ($urandom_range(1) != 0) ? COORD_W'($urandom()) : COORD_W'($urandom_range(4095));
    if (pick < 8) begin
      it.op = OP_MARK;
      return it;
    end
    if (pick < 35) return it;
    k = $urandom_range(LEVELS - 2);
    b = longint'(model_first_dist) << k;
    if (b >= 64'h40_0000) return it;
    span = b / 2 + 2;
    d    = b - span + longint'($urandom_range(0, int'(2 * span)));
    if (d < 0) d = 0;
    rad  = ($urandom_range(9) < 7) ? 0 : longint'($urandom_range(0, int'(d / 8)));
    dx   = d + longint'(rad);
    vpos = longint'($urandom_range(0, int'(64'hFF_FFFF - dx))) - 64'sh80_0000;
    perp = longint'($urandom()) & 64'hFF_FFFF;
    it.rad = COORD_W'(rad);
    // Offset along one axis, equal coordinates on the other.
    if ($urandom_range(1) != 0) begin
      it.vx = COORD_W'(vpos);
      it.cx = COORD_W'(vpos + dx);
      it.vz = COORD_W'(perp);
      it.cz = COORD_W'(perp);
    end else begin
      it.vz = COORD_W'(vpos);
      it.cz = COORD_W'(vpos + dx);
      it.vx = COORD_W'(perp);
      it.cx = COORD_W'(perp);
    end
    if ($urandom_range(1) != 0) begin
      it.cx = it.vx + it.vx - it.cx;
      it.cz = it.vz + it.vz - it.cz;
      if ((it.vx - it.cx) == COORD_W'(0) && (it.vz - it.cz) == COORD_W'(0)) it.cx = it.vx;
    end
    return it;
  endfunction

  // ---------------------------------------------------------------------------------------
  // Channel tasks
  // ---------------------------------------------------------------------------------------

  // Offers one item and returns in the step of the accepting edge. in_valid stays high so
  // a following item goes out back to back; anything that waits calls drain_results first.
  task automatic send_item(input lod_item_t it);
    int gap;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct) gap++;
    @(negedge clk);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid       <= 1'b1;
    in_op          <= it.op;
    in_chunk_index <= it.idx;
    in_center_x    <= it.cx;
    in_center_z    <= it.cz;
    in_viewer_x    <= it.vx;
    in_viewer_z    <= it.vz;
    in_radius      <= it.rad;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    level_expect_q.push_back(select_level(it));
  endtask

  // Sender pauses until every expected result is back, then one item's worth of cycles.
  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (level_expect_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Register write, only with the block idle.
  task automatic write_cfg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] data);
    drain_results();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_FIRST_DIST: begin
        model_first_dist = data[FD_W-1:0];
      end
      CFG_MARGIN: begin
        model_margin = data[MF_W-1:0];
      end
      default: begin
      end
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------------------

  // Default registers: band edges and both hysteresis directions on one chunk.
  task automatic test_band_hysteresis();
    send_idle_pct = 0;
    stall_pct     = 0;
    send_item(dist_item(3, 0));        // unbuilt -> level 0
    send_item(dist_item(3, 16500));    // past 64.0 but inside margin: held
    send_item(dist_item(3, 18022));    // just short of the coarsen edge: held
    send_item(dist_item(3, 18100));    // clears margin -> level 1
    send_item(dist_item(3, 16000));    // below 64.0 but inside margin: held
    send_item(dist_item(3, 14746));    // just above the refine edge: held
    send_item(dist_item(3, 14000));    // -> level 0
    send_item(dist_item(3, 70000));    // jump straight to the last level
    send_item(dist_item(3, 60000));    // refine held by margin
    send_item(dist_item(3, 1000));     // -> level 0
    send_item(mark_item(3));           // unbuilt again
    send_item(dist_item(3, 16500));    // unbuilt: plain band, no hysteresis
    send_item(dist_item(3, 16500));    // same level, no rebuild
  endtask

  // Field extremes and the mark op.
  task automatic test_field_extremes();
    lod_item_t it;
    it     = dist_item(255, 0);
    it.cx  = COORD_W'(-8388608);
    it.vx  = COORD_W'(8388607);
    it.cz  = COORD_W'(8388607);
    it.vz  = COORD_W'(-8388608);
    send_item(it);                     // largest distance
    it.rad = '1;
    send_item(it);                     // largest radius, still below the distance
    it     = dist_item(0, 8388607);
    it.rad = '1;
    send_item(it);
    it.cx  = COORD_W'(-8388608);
    it.rad = '0;
    send_item(it);
    send_item(mark_item(200));         // mark an entry that is already unbuilt
    it     = mark_item(255);
    it.cx  = '1;
    it.cz  = '1;
    it.vx  = '1;
    it.vz  = '1;
    it.rad = '1;
    send_item(it);                     // mark ignores geometry
    send_item(dist_item(255, 0));
    it     = dist_item(128, 0);
    it.vx  = COORD_W'(-1);
    it.vz  = COORD_W'(-1);
    send_item(it);                     // viewer at -1 on both axes, next to the centre
  endtask

  // Register extremes: tiny first distance with no margin, then the largest of both.
  task automatic test_cfg_extremes();
    write_cfg(CFG_FIRST_DIST, CFG_DATA_W'(1));
    write_cfg(CFG_MARGIN, CFG_DATA_W'(0));
    repeat (40) send_item(draw_traffic_item());
    write_cfg(CFG_FIRST_DIST, CFG_DATA_W'(FD_W'(16777215)));
    write_cfg(CFG_MARGIN, CFG_DATA_W'(MF_W'(32767)));
    repeat (40) send_item(draw_traffic_item());
  endtask

  // One random phase: fresh register values, then random traffic with the given idling and stall rate.
  task automatic test_random_traffic(input int idle_pct, input int stall_rate);
    logic [FD_W-1:0] fd;
    fd = ($urandom_range(3) != 0) ? FD_W'($urandom_range(256, 65535))
                                  : FD_W'($urandom_range(1, 16777215));
    write_cfg(CFG_FIRST_DIST, CFG_DATA_W'(fd));
    write_cfg(CFG_MARGIN, CFG_DATA_W'($urandom_range(0, 32767)));
    send_idle_pct = idle_pct;
    stall_rate    = stall_rate;
    stall_pct     = stall_rate;
    repeat (RANDOM_ITEMS) send_item(draw_traffic_item());
  endtask

  // Long receiver hold-off while items keep coming, so the block fills and stalls its
  // input; then the sender waits for every result before the last few items.
  task automatic test_backpressure();
    write_cfg(CFG_FIRST_DIST, CFG_DATA_W'(FIRST_DIST_RST));
    write_cfg(CFG_MARGIN, CFG_DATA_W'(MARGIN_RST));
    send_idle_pct = 0;
    stall_pct     = 0;
    send_item(draw_traffic_item());
    hold_req = 1'b1;
    repeat (8) send_item(draw_traffic_item());
    drain_results();
    repeat (10) send_item(draw_traffic_item());
  endtask

  // ---------------------------------------------------------------------------------------
  // Receiver: random stall, plus a long hold-off on request, counted here.
  // ---------------------------------------------------------------------------------------
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        repeat (HOLD_CYCLES) begin
          out_stall <= 1'b1;
          @(negedge clk);
        end
      end
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // Result check: each accepted result against the oldest expectation.
  always @(posedge clk) begin
    lod_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (level_expect_q.size() == 0) begin
        $error("result with no item pending: new_level=%0d rebuild=%0d",
               out_new_level, out_rebuild);
        fail_cnt++;
      end else begin
        want = level_expect_q.pop_front();
        if (out_new_level !== want.level) begin
          $error("new_level mismatch: expected %0d, got %0d", want.level, out_new_level);
          fail_cnt++;
        end
        if (out_rebuild !== want.rebuild) begin
          $error("rebuild mismatch: expected %0d, got %0d", want.rebuild, out_rebuild);
          fail_cnt++;
        end
      end
    end
  end

  // Watchdog: too many cycles in a row with no handshake on any channel.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------------------
  initial begin
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_op          = OP_EVAL;
    in_chunk_index = '0;
    in_center_x    = '0;
    in_center_z    = '0;
    in_viewer_x    = '0;
    in_viewer_z    = '0;
    in_radius      = '0;
    cfg_valid      = 1'b0;
    cfg_index      = CFG_FIRST_DIST;
    cfg_data       = '0;
    fail_cnt       = 0;
    quiet_cycles   = 0;
    hold_req       = 1'b0;
    send_idle_pct  = 0;
    stall_pct      = 0;
    model_first_dist = FIRST_DIST_RST;
    model_margin     = MARGIN_RST;
    for (int i = 0; i < MAX_CHUNKS; i++) level_tbl[i] = LVL_UNBUILT;

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_band_hysteresis();
    test_field_extremes();
    test_cfg_extremes();
    test_random_traffic(0, 0);
    test_random_traffic(77, 0);
    test_random_traffic(0, 77);
    test_random_traffic(33, 33);
    test_backpressure();
    drain_results();

    if (fail_cnt == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
